// ----- src/srts_pkg.sv -----
// ----------------------------------------------------------------------------
// srts_pkg
// Types and constants shared by the shortest-remaining-time scheduler files.
// ----------------------------------------------------------------------------
package srts_pkg;

  localparam int unsigned MAX_JOBS_DEF = 16;
  localparam int unsigned TIME_W       = 21;
  localparam logic [TIME_W-1:0] TIME_MAX = 21'h1FFFFF;
  localparam logic [15:0] SLICE_RESET  = 16'd10;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_TIME_SLICE = 1'b0;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [2:0] STATUS_LOADED     = 3'd0;
  localparam logic [2:0] STATUS_TABLE_FULL = 3'd1;
  localparam logic [2:0] STATUS_RAN        = 3'd2;
  localparam logic [2:0] STATUS_IDLE_JUMP  = 3'd3;
  localparam logic [2:0] STATUS_ALL_DONE   = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [15:0] job_arrival;
    logic [15:0] job_length;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [3:0]        job_id;
    logic [TIME_W-1:0] event_time;
    logic [15:0]       ran_for;
    logic [15:0]       arrival_of_job;
    logic              first_run;
    logic              job_finished;
    logic [TIME_W-1:0] finish_time;
  } res_t;

  typedef struct packed {
    logic load;
    logic step;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;
  } ctrl_sts_t;

endpackage

// ----- src/srts_ctrl.sv -----
// ----------------------------------------------------------------------------
// srts_ctrl
// Controller: sequences one load or one table scan and its final update.
// ----------------------------------------------------------------------------
module srts_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  req_type_i,
  input  srts_pkg::ctrl_sts_t   sts_i,
  output logic                  busy_o,
  output srts_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_type_i == srts_pkg::REQ_STEP)) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_end) state_d = S_FINISH;
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cmd_o.load   = accept && (req_type_i == srts_pkg::REQ_LOAD);
  assign cmd_o.step   = accept && (req_type_i == srts_pkg::REQ_STEP);
  assign cmd_o.scan   = (state_q == S_SCAN);
  assign cmd_o.finish = (state_q == S_FINISH);

endmodule

// ----- src/srts_datapath.sv -----
// ----------------------------------------------------------------------------
// srts_datapath
// Job table, scan pipeline for the shortest ready job, time keeping and the
// result register.
// ----------------------------------------------------------------------------
module srts_datapath #(
  parameter int unsigned MAX_JOBS = srts_pkg::MAX_JOBS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srts_pkg::ctrl_cmd_t   cmd_i,
  input  srts_pkg::req_t        req_i,
  input  logic [15:0]           time_slice_i,
  output srts_pkg::ctrl_sts_t   sts_o,
  output logic                  res_valid_o,
  output srts_pkg::res_t        res_o
);

  localparam int unsigned IDX_W = $clog2(MAX_JOBS);
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned TW    = srts_pkg::TIME_W;

  logic [15:0] arr_mem [MAX_JOBS];
  logic [15:0] rem_mem [MAX_JOBS];

  logic [CNT_W-1:0]    jobs_loaded_q;
  logic [TW-1:0]       cur_time_q;
  logic [MAX_JOBS-1:0] started_q;
  logic [CNT_W-1:0]    scan_idx_q;
  logic                cmp_vld_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic [15:0]         arr_rd_q, rem_rd_q;
  logic                found_q, first_found_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [15:0]         best_rem_q, best_arr_q, first_arr_q;
  logic                res_valid_q;
  srts_pkg::res_t      res_q;
  srts_pkg::res_t      res_d;

  logic             full, load_we, issue, entry_ready, take;
  logic [IDX_W-1:0] load_addr;
  logic [15:0]      slice, run, rem_left;
  logic [TW:0]      sum;
  logic [TW-1:0]    after;
  logic             rem_we;
  logic [IDX_W-1:0] rem_waddr;
  logic [15:0]      rem_wdata;
  logic [CNT_W+3:0] load_id_wide;
  logic [IDX_W+3:0] best_id_wide;

  assign full         = (jobs_loaded_q == CNT_W'(MAX_JOBS));
  assign load_we      = cmd_i.load && !full;
  assign load_addr    = jobs_loaded_q[IDX_W-1:0];
  assign issue        = cmd_i.scan && (scan_idx_q != jobs_loaded_q);
  assign sts_o.scan_end = (scan_idx_q == jobs_loaded_q);

  assign entry_ready = (rem_rd_q != 16'd0) && ({{(TW-16){1'b0}}, arr_rd_q} <= cur_time_q);
  assign take        = cmp_vld_q && entry_ready && (!found_q || (rem_rd_q < best_rem_q));

  assign slice    = (time_slice_i == 16'd0) ? 16'd1 : time_slice_i;
  assign run      = (best_rem_q < slice) ? best_rem_q : slice;
  assign rem_left = best_rem_q - run;
  assign sum      = {1'b0, cur_time_q} + {{(TW-15){1'b0}}, run};
  assign after    = (sum > {1'b0, srts_pkg::TIME_MAX}) ? srts_pkg::TIME_MAX : sum[TW-1:0];

  assign rem_we    = load_we || (cmd_i.finish && found_q);
  assign rem_waddr = load_we ? load_addr : best_idx_q;
  assign rem_wdata = load_we ? req_i.job_length : rem_left;

  assign load_id_wide = {4'b0, jobs_loaded_q};
  assign best_id_wide = {4'b0, best_idx_q};

  always_comb begin
    res_d = '0;
    if (cmd_i.load) begin
      if (full) begin
        res_d.status = srts_pkg::STATUS_TABLE_FULL;
      end else begin
        res_d.status = srts_pkg::STATUS_LOADED;
        res_d.job_id = load_id_wide[3:0];
      end
    end else begin
      res_d.event_time = cur_time_q;
      if (found_q) begin
        res_d.status         = srts_pkg::STATUS_RAN;
        res_d.job_id         = best_id_wide[3:0];
        res_d.ran_for        = run;
        res_d.arrival_of_job = best_arr_q;
        res_d.first_run      = !started_q[best_idx_q];
        res_d.job_finished   = (rem_left == 16'd0);
        res_d.finish_time    = after;
      end else if (first_found_q) begin
        res_d.status      = srts_pkg::STATUS_IDLE_JUMP;
        res_d.finish_time = {{(TW-16){1'b0}}, first_arr_q};
      end else begin
        res_d.status      = srts_pkg::STATUS_ALL_DONE;
        res_d.finish_time = cur_time_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      arr_mem[load_addr] <= req_i.job_arrival;
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (issue) begin
      arr_rd_q <= arr_mem[scan_idx_q[IDX_W-1:0]];
      rem_rd_q <= rem_mem[scan_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jobs_loaded_q <= '0;
      cur_time_q    <= '0;
      started_q     <= '0;
      scan_idx_q    <= '0;
      cmp_vld_q     <= 1'b0;
      found_q       <= 1'b0;
      first_found_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.load || cmd_i.finish;
      cmp_vld_q   <= issue;
      if (load_we) begin
        jobs_loaded_q        <= jobs_loaded_q + CNT_W'(1);
        started_q[load_addr] <= 1'b0;
      end
      if (cmd_i.step) begin
        scan_idx_q    <= '0;
        found_q       <= 1'b0;
        first_found_q <= 1'b0;
      end
      if (issue) begin
        scan_idx_q <= scan_idx_q + CNT_W'(1);
      end
      if (take) begin
        found_q <= 1'b1;
      end
      if (cmp_vld_q && (rem_rd_q != 16'd0)) begin
        first_found_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        if (found_q) begin
          cur_time_q            <= after;
          started_q[best_idx_q] <= 1'b1;
        end else if (first_found_q) begin
          cur_time_q <= {{(TW-16){1'b0}}, first_arr_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_idx_q <= scan_idx_q[IDX_W-1:0];
    end
    if (take) begin
      best_idx_q <= cmp_idx_q;
      best_rem_q <= rem_rd_q;
      best_arr_q <= arr_rd_q;
    end
    if (cmp_vld_q && (rem_rd_q != 16'd0) && !first_found_q) begin
      first_arr_q <= arr_rd_q;
    end
    if (cmd_i.load || cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/shortest_remaining_time_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_top
// Preemptive shortest-remaining-time scheduler with an APB time slice register.
// ----------------------------------------------------------------------------
// A load is taken and its result beat appears in the next cycle, with busy
// staying low so another request may follow at once. A step holds busy high
// through the scan of the job table and the final update of the chosen job,
// and its result beat appears in the cycle busy falls. The scan reads one
// entry per cycle through the table's single read port, then the compare
// drains before the chosen job is updated. Each result beat is shown for
// exactly one cycle and cannot be held off by the receiver.
// The time slice register should only be written while the block is idle.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_top #(
  parameter int unsigned MAX_JOBS = srts_pkg::MAX_JOBS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  srts_pkg::req_t                req_i,
  output logic                          res_valid_o,
  output srts_pkg::res_t                res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srts_pkg::APB_AW-1:0]   paddr,
  input  logic [srts_pkg::APB_DW-1:0]   pwdata,
  output logic [srts_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [15:0]                  time_slice_q;
  logic [srts_pkg::APB_AW-3:0]  reg_idx;
  srts_pkg::ctrl_cmd_t          cmd;
  srts_pkg::ctrl_sts_t          sts;

  assign reg_idx = paddr[srts_pkg::APB_AW-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == srts_pkg::REG_TIME_SLICE) ? {16'b0, time_slice_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_slice_q <= srts_pkg::SLICE_RESET;
    end else if (psel && penable && pwrite && (reg_idx == srts_pkg::REG_TIME_SLICE)) begin
      time_slice_q <= pwdata[15:0];
    end
  end

  srts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  srts_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_i        (req_i),
    .time_slice_i (time_slice_q),
    .sts_o        (sts),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule

// ----- src/srts_checker.sv -----
// ----------------------------------------------------------------------------
// srts_checker
// Port-level checks of the scheduler's request and result timing and values.
// ----------------------------------------------------------------------------
module srts_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_valid_i,
  input srts_pkg::res_t res_i
);

  a_accept_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (res_valid_i || busy))
    else $error("accepted request produced neither a result nor busy");

  a_step_ends_with_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_i)
    else $error("step finished without a result beat");

  a_ran_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (res_i.status == srts_pkg::STATUS_RAN)) |->
      ((res_i.ran_for != 16'd0) && (res_i.finish_time >= res_i.event_time)))
    else $error("ran beat without progress");

  a_jump_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (res_i.status == srts_pkg::STATUS_IDLE_JUMP)) |->
      (res_i.finish_time > res_i.event_time))
    else $error("idle jump did not move time forward");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (res_i.status == srts_pkg::STATUS_TABLE_FULL)) |->
      ((res_i.job_id == 4'd0) && (res_i.finish_time == '0)))
    else $error("table full beat carries data");

endmodule

bind shortest_remaining_time_scheduler_top srts_checker u_srts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
